// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers for the replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on clk, off while rst_n is low.
`define LAC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk at every edge, reset included.
`define LAC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/lac_pkg.sv
`default_nettype none

package lac_pkg;

  localparam int unsigned WAYS_DEF       = 4;
  localparam int unsigned KEY_BITS_DEF   = 8;
  localparam int unsigned COUNT_BITS_DEF = 8;

  localparam int unsigned LIMIT_BITS = 8;
  localparam int unsigned TOTAL_BITS = 16;
  localparam int unsigned SLOT_BITS  = 2;

  localparam logic [LIMIT_BITS-1:0] IDLE_LIMIT_RST = 8'd10;

endpackage

`default_nettype wire

// File: hw/rtl/lac_req_if.sv
`default_nettype none

interface lac_req_if #(
  parameter int unsigned KEY_BITS = lac_pkg::KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lac_rsp_if.sv
`default_nettype none

interface lac_rsp_if #(
  parameter int unsigned KEY_BITS = lac_pkg::KEY_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [lac_pkg::SLOT_BITS-1:0]    slot;
  logic                             evicted_valid;
  logic [KEY_BITS-1:0]              evicted_key;
  logic [lac_pkg::TOTAL_BITS-1:0]   hit_total;
  logic [lac_pkg::TOTAL_BITS-1:0]   access_total;

  modport source (output valid, output hit, output slot, output evicted_valid,
                  output evicted_key, output hit_total, output access_total,
                  input ready);
  modport sink   (input valid, input hit, input slot, input evicted_valid,
                  input evicted_key, input hit_total, input access_total,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lfu_aging_cache_replacement.sv
// channel   dir  handshake            payload
// req_i     in   valid/ready          key
// rsp_o     out  valid/ready          hit, slot, evicted_valid, evicted_key,
//                                     hit_total, access_total
// cfg       in   cfg_we_i, no stall   idle_limit on cfg_wdata_i
//
// One access per cycle unless rsp_o stalls; path: input register, then
// lookup, victim choice and state update into the response register.
// rst_ni clears slot valid bits, totals, idle_limit (to 10) and both stages.
// A stalled response holds the response register and the input register;
// req_i.ready stays high while the input register can move on.
`default_nettype none
`include "assert_macros.svh"

module lfu_aging_cache_replacement #(
  parameter int unsigned WAYS       = lac_pkg::WAYS_DEF,
  parameter int unsigned KEY_BITS   = lac_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = lac_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lac_req_if.sink                         req_i,
  lac_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [lac_pkg::LIMIT_BITS-1:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TB    = lac_pkg::TOTAL_BITS;

  logic                 in_valid_q;
  logic [KEY_BITS-1:0]  in_key_q;

  logic [WAYS-1:0]      valid_q, valid_d;
  logic [KEY_BITS-1:0]  keys_q     [WAYS];
  logic [KEY_BITS-1:0]  keys_d     [WAYS];
  logic [COUNT_BITS-1:0] use_cnt_q  [WAYS];
  logic [COUNT_BITS-1:0] use_cnt_d  [WAYS];
  logic [COUNT_BITS-1:0] idle_cnt_q [WAYS];
  logic [COUNT_BITS-1:0] idle_cnt_d [WAYS];
  logic [WAYS-1:0]      older_q    [WAYS];
  logic [WAYS-1:0]      older_d    [WAYS];
  logic [TB-1:0]        hits_q, hits_d;
  logic [TB-1:0]        acc_q, acc_d;
  logic [lac_pkg::LIMIT_BITS-1:0] limit_q;

  logic                 rsp_valid_q;
  logic                 rsp_hit_q;
  logic [IDX_W-1:0]     rsp_slot_q;
  logic                 rsp_ev_q;
  logic [KEY_BITS-1:0]  rsp_ev_key_q;

  logic                 advance;
  logic                 proc;
  logic [WAYS-1:0]      hit_vec;
  logic                 hit;
  logic                 full;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     empty_idx;
  logic [IDX_W-1:0]     victim;
  logic [IDX_W-1:0]     sel;
  logic                 evict;
  logic [KEY_BITS-1:0]  ev_key;

  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign proc        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;

  lac_victim #(
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_victim (
    .valid_i    (valid_q),
    .use_cnt_i  (use_cnt_q),
    .idle_cnt_i (idle_cnt_q),
    .older_i    (older_q),
    .limit_i    (limit_q),
    .victim_o   (victim)
  );

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (keys_q[i] == in_key_q);
      if (hit_vec[i]) hit_idx = IDX_W'(i);
      if (!valid_q[i]) empty_idx = IDX_W'(i);
    end
    hit    = |hit_vec;
    full   = &valid_q;
    evict  = !hit && full;
    sel    = hit ? hit_idx : (full ? victim : empty_idx);
    ev_key = evict ? keys_q[victim] : '0;
  end

  always_comb begin
    valid_d    = valid_q;
    keys_d     = keys_q;
    use_cnt_d  = use_cnt_q;
    idle_cnt_d = idle_cnt_q;
    older_d    = older_q;
    hits_d     = hits_q;
    acc_d      = (acc_q == '1) ? acc_q : TB'(acc_q + 1'b1);

    valid_d[sel] = 1'b1;
    if (hit) begin
      hits_d         = (hits_q == '1) ? hits_q : TB'(hits_q + 1'b1);
      use_cnt_d[sel] = (use_cnt_q[sel] == '1) ? use_cnt_q[sel] :
                       COUNT_BITS'(use_cnt_q[sel] + 1'b1);
    end else begin
      keys_d[sel]    = in_key_q;
      use_cnt_d[sel] = COUNT_BITS'(1);
      // make the filled slot newest in fill order
      older_d[sel]   = '0;
      for (int j = 0; j < WAYS; j++) begin
        if (IDX_W'(j) != sel) older_d[j][sel] = 1'b1;
      end
    end

    for (int i = 0; i < WAYS; i++) begin
      if (valid_d[i]) begin
        if (IDX_W'(i) == sel) begin
          idle_cnt_d[i] = '0;
        end else begin
          idle_cnt_d[i] = (idle_cnt_q[i] == '1) ? idle_cnt_q[i] :
                          COUNT_BITS'(idle_cnt_q[i] + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
      hits_q      <= '0;
      acc_q       <= '0;
      limit_q     <= lac_pkg::IDLE_LIMIT_RST;
    end else begin
      if (req_i.ready) in_valid_q <= req_i.valid;
      if (proc) begin
        rsp_valid_q <= 1'b1;
        valid_q     <= valid_d;
        hits_q      <= hits_d;
        acc_q       <= acc_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) in_key_q <= req_i.key;
    if (proc) begin
      keys_q       <= keys_d;
      use_cnt_q    <= use_cnt_d;
      idle_cnt_q   <= idle_cnt_d;
      older_q      <= older_d;
      rsp_hit_q    <= hit;
      rsp_slot_q   <= sel;
      rsp_ev_q     <= evict;
      rsp_ev_key_q <= ev_key;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = rsp_hit_q;
  assign rsp_o.slot          = lac_pkg::SLOT_BITS'(rsp_slot_q);
  assign rsp_o.evicted_valid = rsp_ev_q;
  assign rsp_o.evicted_key   = rsp_ev_key_q;
  assign rsp_o.hit_total     = hits_q;
  assign rsp_o.access_total  = acc_q;

  `LAC_ASSERT(a_evict_when_full, clk_i, rst_ni, rsp_valid_q && rsp_ev_q |-> !rsp_hit_q && (&valid_q), "eviction reported while a slot was empty")
  `LAC_ASSERT(a_slot_valid, clk_i, rst_ni, proc |=> valid_q[$past(sel)], "reported slot not valid after access")
  `LAC_ASSERT(a_valid_keep, clk_i, rst_ni, 1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)), "slot valid bit dropped")
  `LAC_ASSERT(a_acc_step, clk_i, rst_ni, proc && (acc_q != '1) |=> acc_q == $past(acc_q) + 1'b1, "access total missed an item")
  `LAC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !rsp_valid_q && !in_valid_q, "pipeline busy during reset")

endmodule

`default_nettype wire

// File: hw/rtl/lac_victim.sv
`default_nettype none

module lac_victim #(
  parameter int unsigned WAYS       = lac_pkg::WAYS_DEF,
  parameter int unsigned COUNT_BITS = lac_pkg::COUNT_BITS_DEF,
  localparam int unsigned IDX_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS-1:0]                  valid_i,
  input  logic [COUNT_BITS-1:0]            use_cnt_i  [WAYS],
  input  logic [COUNT_BITS-1:0]            idle_cnt_i [WAYS],
  input  logic [WAYS-1:0]                  older_i    [WAYS],
  input  logic [lac_pkg::LIMIT_BITS-1:0]   limit_i,
  output logic [IDX_W-1:0]                 victim_o
);

  localparam int unsigned CW = (COUNT_BITS > lac_pkg::LIMIT_BITS) ?
                               COUNT_BITS : lac_pkg::LIMIT_BITS;

  logic [WAYS-1:0] idle_hit;
  logic [WAYS-1:0] lfu_win;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      idle_hit[i] = valid_i[i] && (CW'(idle_cnt_i[i]) > CW'(limit_i));
      lfu_win[i]  = valid_i[i];
      for (int j = 0; j < WAYS; j++) begin
        if (j != i && valid_i[j] &&
            !((use_cnt_i[i] < use_cnt_i[j]) ||
              ((use_cnt_i[i] == use_cnt_i[j]) && older_i[i][j]))) begin
          lfu_win[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    victim_o = '0;
    if (|idle_hit) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (idle_hit[i]) victim_o = IDX_W'(i);
      end
    end else begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (lfu_win[i]) victim_o = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
module testbench;

  localparam int unsigned WAYS       = lac_pkg::WAYS_DEF;
  localparam int unsigned KEY_BITS   = lac_pkg::KEY_BITS_DEF;
  localparam int unsigned COUNT_BITS = lac_pkg::COUNT_BITS_DEF;
  localparam int unsigned LIMIT_BITS = lac_pkg::LIMIT_BITS;
  localparam int unsigned TOTAL_BITS = lac_pkg::TOTAL_BITS;
  localparam int unsigned SLOT_BITS  = lac_pkg::SLOT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_TOP = '1;

  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_BITS-1:0]  slot;
    logic                  evicted_valid;
    logic [KEY_BITS-1:0]   evicted_key;
    logic [TOTAL_BITS-1:0] hit_total;
    logic [TOTAL_BITS-1:0] access_total;
  } access_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [LIMIT_BITS-1:0] cfg_wdata_i;

  lac_req_if #(.KEY_BITS(KEY_BITS)) access_req ();
  lac_rsp_if #(.KEY_BITS(KEY_BITS)) access_rsp ();

  lfu_aging_cache_replacement #(
    .WAYS      (WAYS),
    .KEY_BITS  (KEY_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (access_req),
    .rsp_o      (access_rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Shadow copy of the key store
  logic [KEY_BITS-1:0]   line_key   [WAYS];
  bit                    line_valid [WAYS];
  logic [COUNT_BITS-1:0] line_use   [WAYS];
  logic [COUNT_BITS-1:0] line_idle  [WAYS];
  int unsigned           fill_order [$];
  logic [TOTAL_BITS-1:0] hit_sum;
  logic [TOTAL_BITS-1:0] access_sum;
  logic [LIMIT_BITS-1:0] idle_limit_model;

  logic [KEY_BITS-1:0] pending_keys       [$];
  access_result_t      expected_responses [$];

  int unsigned mismatch_count;
  int unsigned responses_seen;
  bit          sender_gaps;
  bit          receiver_stalls;
  bit          long_hold_armed;

  function automatic void age_lines(int unsigned fresh);
    for (int i = 0; i < WAYS; i++) begin
      if (line_valid[i]) begin
        if (i == fresh) line_idle[i] = '0;
        else if (line_idle[i] != COUNT_TOP) line_idle[i] = line_idle[i] + 1'b1;
      end
    end
  endfunction

  function automatic int unsigned choose_victim();
    logic [COUNT_BITS-1:0] low_use;
    low_use = COUNT_TOP;
    for (int i = 0; i < WAYS; i++) begin
      if (line_valid[i] && line_idle[i] > idle_limit_model) return i;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (line_valid[i] && line_use[i] < low_use) low_use = line_use[i];
    end
    foreach (fill_order[j]) begin
      if (line_valid[fill_order[j]] && line_use[fill_order[j]] == low_use) return fill_order[j];
    end
    return 0;
  endfunction

  function automatic void predict_access(logic [KEY_BITS-1:0] key);
    access_result_t res;
    int unsigned    s;
    bit             found;
    res   = '0;
    s     = 0;
    found = 1'b0;
    if (access_sum != TOTAL_TOP) access_sum = access_sum + 1'b1;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && line_valid[i] && line_key[i] == key) begin
        found = 1'b1;
        s = i;
      end
    end
    if (found) begin
      if (hit_sum != TOTAL_TOP) hit_sum = hit_sum + 1'b1;
      age_lines(s);
      if (line_use[s] != COUNT_TOP) line_use[s] = line_use[s] + 1'b1;
    end else begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (!line_valid[i]) begin
          s = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        s = choose_victim();
        res.evicted_valid = 1'b1;
        res.evicted_key   = line_key[s];
      end
      line_key[s]   = key;
      line_valid[s] = 1'b1;
      age_lines(s);
      line_use[s] = COUNT_BITS'(1);
      foreach (fill_order[j]) begin
        if (fill_order[j] == s) begin
          fill_order.delete(j);
          break;
        end
      end
      fill_order.push_back(s);
      found = 1'b0;
    end
    res.hit          = found;
    res.slot         = s[SLOT_BITS-1:0];
    res.hit_total    = hit_sum;
    res.access_total = access_sum;
    expected_responses.push_back(res);
  endfunction

  function automatic void report_mismatch(string field, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch in %s at response %0d: expected 0x%0h, got 0x%0h",
               field, responses_seen, want, got);
    end
  endfunction

  // Driver: bursts of items with random gaps between them when sender_gaps is set
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_req.valid <= 1'b0;
      access_req.key   <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (access_req.valid && access_req.ready) begin
        predict_access(access_req.key);
        void'(pending_keys.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
          gap_left = sender_gaps ? $urandom_range(0, 7) : 0;
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        access_req.valid <= 1'b0;
      end else if (pending_keys.size() > 0) begin
        access_req.valid <= 1'b1;
        access_req.key   <= pending_keys[0];
      end else begin
        access_req.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each response, then pick next ready
  logic [15:0] ready_pattern;
  int unsigned pattern_step;
  int unsigned hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_rsp.ready <= 1'b0;
      ready_pattern = 16'hF3B7;
      pattern_step  = 0;
      hold_left     = 0;
    end else begin
      if (access_rsp.valid && access_rsp.ready) begin
        responses_seen++;
        if (expected_responses.size() == 0) begin
          report_mismatch("response count", 0, 1);
        end else begin
          if (access_rsp.hit !== expected_responses[0].hit)
            report_mismatch("hit", expected_responses[0].hit, access_rsp.hit);
          if (access_rsp.slot !== expected_responses[0].slot)
            report_mismatch("slot", expected_responses[0].slot, access_rsp.slot);
          if (access_rsp.evicted_valid !== expected_responses[0].evicted_valid)
            report_mismatch("evicted_valid", expected_responses[0].evicted_valid,
                            access_rsp.evicted_valid);
          if (access_rsp.evicted_key !== expected_responses[0].evicted_key)
            report_mismatch("evicted_key", expected_responses[0].evicted_key,
                            access_rsp.evicted_key);
          if (access_rsp.hit_total !== expected_responses[0].hit_total)
            report_mismatch("hit_total", expected_responses[0].hit_total,
                            access_rsp.hit_total);
          if (access_rsp.access_total !== expected_responses[0].access_total)
            report_mismatch("access_total", expected_responses[0].access_total,
                            access_rsp.access_total);
          void'(expected_responses.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        access_rsp.ready <= 1'b0;
      end else if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        hold_left = LONG_HOLD - 1;
        access_rsp.ready <= 1'b0;
      end else if (!receiver_stalls) begin
        access_rsp.ready <= 1'b1;
      end else begin
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        pattern_step++;
        if (pattern_step == 16) begin
          pattern_step = 0;
          ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        access_rsp.ready <= ready_pattern[0];
      end
    end
  end

  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (access_req.valid && access_req.ready) ||
        (access_rsp.valid && access_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_keys.size() != 0 || expected_responses.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_idle_limit(logic [LIMIT_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    idle_limit_model = value;
    @(negedge clk_i);
  endtask

  // Mostly a small working set so hits, LFU and idle evictions all occur
  task automatic queue_random_keys(int unsigned count);
    logic [KEY_BITS-1:0] working_set [6];
    foreach (working_set[i]) working_set[i] = KEY_BITS'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) pending_keys.push_back(KEY_BITS'($urandom));
      else pending_keys.push_back(working_set[$urandom_range(0, 5)]);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    access_req.valid = 1'b0;
    access_req.key   = '0;
    access_rsp.ready = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_use[i]   = '0;
      line_idle[i]  = '0;
    end
    hit_sum          = '0;
    access_sum       = '0;
    idle_limit_model = lac_pkg::IDLE_LIMIT_RST;
    mismatch_count   = 0;
    responses_seen   = 0;
    sender_gaps      = 1'b1;
    receiver_stalls  = 1'b1;
    long_hold_armed  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill, hit, LFU eviction with first-in tie-break, then idle eviction
    pending_keys = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h01, 8'h02};
    repeat (6) begin
      pending_keys.push_back(8'h00);
      pending_keys.push_back(8'hFF);
    end
    pending_keys.push_back(8'h03);
    pending_keys.push_back(8'h03);
    pending_keys.push_back(8'hFE);
    wait_drained();

    write_idle_limit(8'd0);
    long_hold_armed = 1'b1;
    queue_random_keys(25);
    wait_drained();

    write_idle_limit(8'd3);
    queue_random_keys(25);
    wait_drained();

    write_idle_limit(LIMIT_BITS'($urandom));
    queue_random_keys(25);
    wait_drained();

    write_idle_limit(8'd1);
    queue_random_keys(25);
    wait_drained();

    // Saturate one use count and the idle counts of the other entries
    write_idle_limit(8'd255);
    pending_keys = '{8'hC0, 8'hC1, 8'hC2, 8'hC3};
    repeat (256) pending_keys.push_back(8'hC0);
    pending_keys.push_back(8'hC4);
    queue_random_keys(10);
    wait_drained();

    // Run at full rate
    write_idle_limit(lac_pkg::IDLE_LIMIT_RST);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    queue_random_keys(20);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
